// ----- hw/rtl/ptw4_pkg.sv -----
// shared types and constants for the four-level page table walker
// no dependencies; imported by every walker module

package ptw4_pkg;

  localparam int unsigned PaddrBits = 52;  // physical address width kept by the walker
  localparam int unsigned VaddrBits = 48;
  localparam int unsigned AddrW     = 52;  // width of the mem_addr field
  localparam int unsigned RootW     = 40;
  localparam int unsigned EntryW    = 64;
  localparam int unsigned StatusW   = 3;

  // input word kinds
  localparam logic ReqTranslate = 1'b0;
  localparam logic ReqResponse  = 1'b1;

  // result word kinds
  localparam logic ResRead = 1'b0;
  localparam logic ResDone = 1'b1;

  localparam logic [StatusW-1:0] StatusOk = 3'd0;

  // entry bit positions
  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitWrite   = 1;
  localparam int unsigned BitUser    = 2;
  localparam int unsigned BitNoExec  = 63;

  typedef struct packed {
    logic write;
    logic user;
    logic ifetch;
  } access_t;

  typedef struct packed {
    logic                 busy;
    logic [1:0]           level;
    logic [VaddrBits-1:0] vaddr;
    access_t              access;
    logic [AddrW-1:0]     entry_addr;
  } walk_state_t;

  typedef struct packed {
    logic                 req_type;
    logic [VaddrBits-1:0] virt_addr;
    access_t              access;
    logic [EntryW-1:0]    read_data;
  } walk_in_t;

  typedef struct packed {
    logic               res_type;
    logic [AddrW-1:0]   mem_addr;
    logic [StatusW-1:0] status;
    logic [EntryW-1:0]  entry_value;
  } walk_res_t;

endpackage

// ----- hw/rtl/ptw4_step.sv -----
// next-state and result logic for one input word of the walker
// depends on ptw4_pkg

module ptw4_step
  import ptw4_pkg::*;
(
  input  walk_state_t      state_i,
  input  walk_in_t         word_i,
  input  logic [RootW-1:0] root_page_i,
  output walk_state_t      state_o,
  output walk_res_t        res_o,
  output logic             emit_o
);

  logic [VaddrBits-1:0] vaddr;
  logic [1:0]           lvl;
  logic [8:0]           idx;
  logic [AddrW-1:0]     base;
  logic [AddrW-1:0]     addr;
  logic                 ok;
  logic                 last;
  logic [EntryW-1:0]    e;

  assign e = word_i.read_data;

  // permission check against the saved access kind
  assign ok = e[BitPresent]
            & (~state_i.access.write  | e[BitWrite])
            & (~state_i.access.user   | e[BitUser])
            & ~(state_i.access.ifetch & e[BitNoExec]);

  assign last = (state_i.level == 2'd3);

  always_comb begin
    // address for the level being asked for next
    if (word_i.req_type == ReqTranslate) begin
      vaddr = word_i.virt_addr;
      lvl   = 2'd0;
      base  = '0;
      base[PaddrBits-1:12] = root_page_i[PaddrBits-13:0];
    end else begin
      vaddr = state_i.vaddr;
      lvl   = state_i.level + 2'd1;
      base  = '0;
      base[PaddrBits-1:12] = e[PaddrBits-1:12];
    end
    unique case (lvl)
      2'd0:    idx = vaddr[47:39];
      2'd1:    idx = vaddr[38:30];
      2'd2:    idx = vaddr[29:21];
      default: idx = vaddr[20:12];
    endcase
    addr = {base[AddrW-1:12], idx, 3'b000};
  end

  always_comb begin
    state_o = state_i;
    res_o   = '{res_type: ResRead, mem_addr: addr, status: StatusOk, entry_value: '0};
    emit_o  = 1'b0;
    if (word_i.req_type == ReqTranslate) begin
      if (!state_i.busy) begin
        state_o.busy       = 1'b1;
        state_o.level      = 2'd0;
        state_o.vaddr      = word_i.virt_addr;
        state_o.access     = word_i.access;
        state_o.entry_addr = addr;
        emit_o             = 1'b1;
      end
    end else if (state_i.busy) begin
      emit_o = 1'b1;
      if (!ok || last) begin
        state_o.busy      = 1'b0;
        res_o.res_type    = ResDone;
        res_o.mem_addr    = state_i.entry_addr;
        res_o.status      = ok ? StatusOk : {1'b0, state_i.level} + 3'd1;
        res_o.entry_value = e;
      end else begin
        state_o.level      = lvl;
        state_o.entry_addr = addr;
      end
    end
  end

endmodule

// ----- hw/rtl/ptw4_out_buf.sv -----
// result register with one skid entry behind it
// depends on ptw4_pkg

module ptw4_out_buf
  import ptw4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  walk_res_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      ready_i,
  output walk_res_t data_o
);

  logic      main_valid_q;
  logic      skid_valid_q;
  walk_res_t main_q;
  walk_res_t skid_q;
  logic      pop;

  assign pop     = main_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!main_valid_q || pop) begin
          main_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        main_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without a result in front");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && pop |=> main_valid_q && !skid_valid_q)
    else $error("skid entry lost on pop");

endmodule

// ----- hw/rtl/page_table_walker_4level_core.sv -----
// top level of the four-level page table walker
// depends on ptw4_pkg, ptw4_step and ptw4_out_buf
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries translate requests and
//   memory read responses, told apart by req_type_i. output channel
//   (out_valid_o / out_ready_i) carries read requests for the next table
//   entry and the final walk result. memory sits outside: the user feeds
//   each read request to memory and returns the entry as a response word.
//   root_table_page is to be written through cfg_we_i / cfg_wdata_i only
//   while idle, by the user; the block itself does not enforce this.
// throughput: one input word per cycle when in_ready_o is high; a walk costs
//   one translate word and up to four response words. words doing nothing
//   (a request mid-walk, a response while idle) are taken, with no result.
// reset clears the walk state, the root page and the result buffer.
// when the receiver stalls, the result register holds and one more word is
//   taken into the skid entry; after that in_ready_o drops until it drains.

module page_table_walker_4level_core
  import ptw4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RootW-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [VaddrBits-1:0] virt_addr_i,
  input  logic                 want_write_i,
  input  logic                 want_user_i,
  input  logic                 want_ifetch_i,
  input  logic [EntryW-1:0]    read_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 res_type_o,
  output logic [AddrW-1:0]     mem_addr_o,
  output logic [StatusW-1:0]   status_o,
  output logic [EntryW-1:0]    entry_value_o
);

  logic [RootW-1:0] root_q;
  walk_state_t      state_q;
  walk_state_t      state_d;
  walk_in_t         word;
  walk_res_t        res;
  walk_res_t        out_data;
  logic             emit;
  logic             accept;

  assign accept = in_valid_i & in_ready_o;

  assign word = '{req_type:  req_type_i,
                  virt_addr: virt_addr_i,
                  access:    '{write: want_write_i, user: want_user_i,
                               ifetch: want_ifetch_i},
                  read_data: read_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  ptw4_step u_step (
    .state_i     (state_q),
    .word_i      (word),
    .root_page_i (root_q),
    .state_o     (state_d),
    .res_o       (res),
    .emit_o      (emit)
  );

  ptw4_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept & emit),
    .data_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign res_type_o    = out_data.res_type;
  assign mem_addr_o    = out_data.mem_addr;
  assign status_o      = out_data.status;
  assign entry_value_o = out_data.entry_value;

  a_translate_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqTranslate && !state_q.busy |=> state_q.busy)
    else $error("translate request did not start a walk");

  a_fail_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> res_type_o == ResDone)
    else $error("failure status on a read request");

  a_read_has_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_type_o == ResRead |-> entry_value_o == '0)
    else $error("read request carries entry data");

  a_idle_response_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqResponse && !state_q.busy |=> !state_q.busy)
    else $error("response while idle changed the walk state");

endmodule
